// ----- src/lpht_pkg.sv -----
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear-probing hash table: item
// structs, command codes and the stored slot format.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int KEY_W           = 31;
    localparam int IDX_W           = 6;
    localparam int TABLE_SLOTS_DEF = 64;
    // key bits folded into the remainder per cycle when the table size is
    // not a power of two
    localparam int MOD_RADIX       = 4;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]       command;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic             success;
        logic [IDX_W-1:0] slot_index;
    } rsp_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage

// ----- src/lpht_ram.sv -----
// ----------------------------------------------------------------------------
// lpht_ram
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/lpht_mod.sv -----
// ----------------------------------------------------------------------------
// lpht_mod
// Home slot unit: key modulo the table size. Power-of-two sizes take the
// low bits into a register; other sizes run a restoring remainder, MOD_RADIX
// key bits per cycle.
// ----------------------------------------------------------------------------
module lpht_mod #(
    parameter int SLOTS = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [lpht_pkg::KEY_W-1:0] key,
    output logic                     done,
    output logic [$clog2(SLOTS)-1:0] rem
);

    import lpht_pkg::*;

    localparam int IW   = $clog2(SLOTS);
    localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);

    logic          done_reg;
    logic [IW-1:0] rem_reg;

    generate
        if (POW2)
        begin : g_mask
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= key[IW-1:0];
                end
            end
        end
        else
        begin : g_iter
            localparam int PW    = ((KEY_W + MOD_RADIX - 1) / MOD_RADIX) * MOD_RADIX;
            localparam int STEPS = PW / MOD_RADIX;
            localparam int SW    = $clog2(STEPS + 1);
            localparam logic [IW:0] LIM = (IW + 1)'(SLOTS);

            logic          busy_reg;
            logic [SW-1:0] step_reg;
            logic [PW-1:0] shf_reg;
            logic [IW-1:0] rem_step;
            logic [IW:0]   t;
            logic [IW-1:0] r;

            // r < SLOTS always, so 2r+1 < 2*SLOTS needs one subtract
            always_comb
            begin
                r = rem_reg;
                t = '0;
                for (int b = 0; b < MOD_RADIX; b++)
                begin
                    t = {r, shf_reg[PW-1-b]};
                    if (t >= LIM)
                    begin
                        t = t - LIM;
                    end
                    r = t[IW-1:0];
                end
                rem_step = r;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    step_reg <= '0;
                end
                else
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        busy_reg <= 1'b1;
                        step_reg <= '0;
                    end
                    else if (busy_reg)
                    begin
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == SW'(STEPS - 1))
                        begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    shf_reg <= PW'(key);
                    rem_reg <= '0;
                end
                else if (busy_reg)
                begin
                    shf_reg <= shf_reg << MOD_RADIX;
                    rem_reg <= rem_step;
                end
            end
        end
    endgenerate

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- src/linear_probe_hash_table.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressed hash set with linear probing and backward-shift removal.
// Slots (valid bit and key) live in one synchronous RAM; a sequencer walks
// the probe path one slot at a time.
// ----------------------------------------------------------------------------
// Sequence: home lookup, then a read and an evaluation per probed slot and
//   a load of the result; remove then reads each following slot, redoes the
//   home lookup for each occupied one and clears the hole at the end.
// Throughput: one item at a time; the next is taken while the result waits.
// Reset: the sequencer clears all TABLE_SLOTS slots, one per cycle, before
//   the first item is accepted.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  lpht_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output lpht_pkg::rsp_t rsp
);

    import lpht_pkg::*;

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam logic [IW-1:0] LAST  = IW'(TABLE_SLOTS - 1);
    localparam logic [CW-1:0] COUNT = CW'(TABLE_SLOTS);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HOME,
        S_PROBE_RD,
        S_PROBE_EV,
        S_GAP_RD,
        S_GAP_EV,
        S_GAP_HOME,
        S_FINISH,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [KEY_W-1:0] gkey_reg, gkey_next;
    logic [IW-1:0]    ptr_reg, ptr_next;
    logic [IW-1:0]    hole_reg, hole_next;
    logic [IW-1:0]    where_reg, where_next;
    logic [CW-1:0]    n_reg, n_next;
    logic             ok_reg, ok_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic             mem_we;
    logic [IW-1:0]    mem_wa;
    slot_t            mem_wd;
    logic             mem_re;
    logic [IW-1:0]    mem_ra;
    logic [SLOT_W-1:0] mem_rd;
    slot_t            rd_slot;

    logic             mod_start;
    logic [KEY_W-1:0] mod_key;
    logic             mod_done;
    logic [IW-1:0]    mod_rem;

    logic [IW-1:0]    ptr_inc;
    logic [CW-1:0]    n_inc;
    logic             key_hit;
    logic             movable;

    lpht_ram #(
        .DEPTH (TABLE_SLOTS),
        .WIDTH (SLOT_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_wa),
        .wr_data (mem_wd),
        .rd_en   (mem_re),
        .rd_addr (mem_ra),
        .rd_data (mem_rd)
    );

    lpht_mod #(
        .SLOTS (TABLE_SLOTS)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .key   (mod_key),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    assign rd_slot = slot_t'(mem_rd);
    assign ptr_inc = (ptr_reg == LAST) ? '0 : ptr_reg + 1'b1;
    assign n_inc   = n_reg + 1'b1;
    assign key_hit = (rd_slot.key == key_reg);

    // entry at ptr may move into the hole when its home is not cyclically
    // inside (hole, ptr]
    assign movable = ((mod_rem <= hole_reg) && (hole_reg < ptr_reg)) ||
                     ((hole_reg < ptr_reg) && (ptr_reg < mod_rem)) ||
                     ((ptr_reg < mod_rem) && (mod_rem <= hole_reg));

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        gkey_next      = gkey_reg;
        ptr_next       = ptr_reg;
        hole_next      = hole_reg;
        where_next     = where_reg;
        n_next         = n_reg;
        ok_next        = ok_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        mem_we    = 1'b0;
        mem_wa    = ptr_reg;
        mem_wd    = '0;
        mem_re    = 1'b0;
        mem_ra    = ptr_reg;
        mod_start = 1'b0;
        mod_key   = key_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_inc;
                if (ptr_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = req.command;
                    key_next   = req.key;
                    ok_next    = 1'b0;
                    where_next = '0;
                    unique case (req.command) inside
                        CMD_INSERT, CMD_SEARCH, CMD_REMOVE:
                        begin
                            mod_start  = 1'b1;
                            mod_key    = req.key;
                            state_next = S_HOME;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_HOME:
            begin
                if (mod_done)
                begin
                    ptr_next   = mod_rem;
                    n_next     = '0;
                    state_next = S_PROBE_RD;
                end
            end

            S_PROBE_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_PROBE_EV;
            end

            S_PROBE_EV:
            begin
                if (!rd_slot.valid)
                begin
                    if (cmd_reg == CMD_INSERT)
                    begin
                        mem_we     = 1'b1;
                        mem_wd     = '{valid: 1'b1, key: key_reg};
                        ok_next    = 1'b1;
                        where_next = ptr_reg;
                    end
                    state_next = S_DONE;
                end
                else if ((cmd_reg != CMD_INSERT) && key_hit)
                begin
                    ok_next    = 1'b1;
                    where_next = ptr_reg;
                    if (cmd_reg == CMD_REMOVE)
                    begin
                        // the hole is written back only when the shift ends
                        hole_next  = ptr_reg;
                        ptr_next   = ptr_inc;
                        n_next     = '0;
                        state_next = S_GAP_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    n_next   = n_inc;
                    ptr_next = ptr_inc;
                    if (n_inc == COUNT)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PROBE_RD;
                    end
                end
            end

            S_GAP_RD:
            begin
                if (n_reg == COUNT)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_GAP_EV;
                end
            end

            S_GAP_EV:
            begin
                // the open hole still holds stale contents in the RAM
                if (!rd_slot.valid || (ptr_reg == hole_reg))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    gkey_next  = rd_slot.key;
                    mod_start  = 1'b1;
                    mod_key    = rd_slot.key;
                    state_next = S_GAP_HOME;
                end
            end

            S_GAP_HOME:
            begin
                if (mod_done)
                begin
                    if (movable)
                    begin
                        mem_we    = 1'b1;
                        mem_wa    = hole_reg;
                        mem_wd    = '{valid: 1'b1, key: gkey_reg};
                        hole_next = ptr_reg;
                    end
                    ptr_next   = ptr_inc;
                    n_next     = n_inc;
                    state_next = S_GAP_RD;
                end
            end

            S_FINISH:
            begin
                mem_we     = 1'b1;
                mem_wa     = hole_reg;
                mem_wd     = '0;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.success    = ok_reg;
                    rsp_next.slot_index = ok_reg ? IDX_W'(where_reg) : '0;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ptr_reg       <= '0;
            n_reg         <= '0;
            ok_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            n_reg         <= n_next;
            ok_reg        <= ok_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        gkey_reg  <= gkey_next;
        hole_reg  <= hole_next;
        where_reg <= where_next;
        rsp_reg   <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- tb/lpht_checker.sv -----
// ----------------------------------------------------------------------------
// lpht_checker
// Watches both channels of the hash table. Each accepted request item is run
// through a local copy of the table (linear probing, backward-shift removal)
// and each accepted response item is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module lpht_checker #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  lpht_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  lpht_pkg::rsp_t rsp,
    output int             errors,
    output int             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lpht_pkg::*;

    logic             slot_used [TABLE_SLOTS];
    logic [KEY_W-1:0] slot_key  [TABLE_SLOTS];
    rsp_t             expected_rsps[$];

    function automatic int unsigned home_slot(input logic [KEY_W-1:0] k);
        return {1'b0, k} % TABLE_SLOTS;
    endfunction

    function automatic int unsigned next_slot(input int unsigned i);
        return (i + 1) % TABLE_SLOTS;
    endfunction

    function automatic bit find_key(input logic [KEY_W-1:0] k, output int unsigned at);
        int unsigned i;
        i  = home_slot(k);
        at = 0;
        for (int n = 0; n < TABLE_SLOTS; n++)
        begin
            if (!slot_used[i])
                return 1'b0;
            if (slot_key[i] == k)
            begin
                at = i;
                return 1'b1;
            end
            i = next_slot(i);
        end
        return 1'b0;
    endfunction

    // pull later cluster members back into the hole so every key stays
    // reachable from its home slot
    function automatic void close_gap(input int unsigned hole);
        int unsigned i;
        int unsigned h;
        i = next_slot(hole);
        for (int n = 0; n < TABLE_SLOTS && slot_used[i]; n++)
        begin
            h = home_slot(slot_key[i]);
            if ((h <= hole && hole < i) || (hole < i && i < h) || (i < h && h <= hole))
            begin
                slot_key[hole]  = slot_key[i];
                slot_used[hole] = 1'b1;
                slot_used[i]    = 1'b0;
                hole            = i;
            end
            i = next_slot(i);
        end
    endfunction

    function automatic rsp_t apply_request(input req_t r);
        rsp_t        res;
        int unsigned i;
        int unsigned at;
        bit          hit;
        hit = 1'b0;
        at  = 0;
        case (r.command)
            CMD_INSERT:
            begin
                i = home_slot(r.key);
                for (int n = 0; n < TABLE_SLOTS && !hit; n++)
                begin
                    if (!slot_used[i])
                    begin
                        slot_used[i] = 1'b1;
                        slot_key[i]  = r.key;
                        at           = i;
                        hit          = 1'b1;
                    end
                    else
                        i = next_slot(i);
                end
            end
            CMD_SEARCH:
                hit = find_key(r.key, at);
            CMD_REMOVE:
            begin
                hit = find_key(r.key, at);
                if (hit)
                begin
                    slot_used[at] = 1'b0;
                    close_gap(at);
                end
            end
            default:
                hit = 1'b0;
        endcase
        res.success    = hit;
        res.slot_index = hit ? IDX_W'(at) : '0;
        return res;
    endfunction

    initial
    begin
        errors  = 0;
        pending = 0;
        for (int s = 0; s < TABLE_SLOTS; s++)
        begin
            slot_used[s] = 1'b0;
            slot_key[s]  = '0;
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        int   bad;
        bad = 0;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: unexpected result item, got success %0b slot %0d",
                             $time, rsp.success, rsp.slot_index);
                    bad++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.success !== want.success)
                    begin
                        $display("%0t: success mismatch, expected %0b, got %0b",
                                 $time, want.success, rsp.success);
                        bad++;
                    end
                    if (rsp.slot_index !== want.slot_index)
                    begin
                        $display("%0t: slot_index mismatch, expected %0d, got %0d",
                                 $time, want.slot_index, rsp.slot_index);
                        bad++;
                    end
                end
            end
            if (req_valid && !req_stall)
                expected_rsps.push_back(apply_request(req));
        end
        errors  <= errors + bad;
        pending <= expected_rsps.size();
    end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for linear_probe_hash_table: directed probe-chain
// cases, then random insert/search/remove mixes over clustered and spread
// keys, a full-table phase and a drain, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lpht_pkg::*;

    localparam int         TABLE_SLOTS = TABLE_SLOTS_DEF;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         TAIL_CYCLES = 1000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;
    int   fail_count;
    int   pending_results;

    bit               no_idle  = 1'b0;
    bit               hold_rsp = 1'b0;
    logic [KEY_W-1:0] live_keys[$];

    linear_probe_hash_table #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    lpht_checker #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .errors    (fail_count),
        .pending   (pending_results)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("linear_probe_hash_table test failed");
        $finish;
    end

    // response side: random stall per item, one long hold-off on request
    initial
    begin
        int n;
        forever
        begin
            if (hold_rsp)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
            n = no_idle ? 0 : $urandom_range(0, 7);
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
        end
    end

    // offers one item and keeps a list of keys the table should hold
    task automatic apply_op(input logic [1:0] cmd, input logic [KEY_W-1:0] k);
        int gap;
        bit done;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{command: cmd, key: k};
        @(posedge clk);
        while (req_stall) @(posedge clk);
        done = 1'b0;
        if (cmd == CMD_INSERT && live_keys.size() < TABLE_SLOTS)
            live_keys.push_back(k);
        if (cmd == CMD_REMOVE)
            for (int j = 0; j < live_keys.size() && !done; j++)
                if (live_keys[j] == k)
                begin
                    live_keys.delete(j);
                    done = 1'b1;
                end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
    endtask

    // random upper bits, home slot near base so probe chains collide
    function automatic logic [KEY_W-1:0] clustered_key(input int base);
        logic [KEY_W-1:0] k;
        k            = KEY_W'($urandom);
        k[IDX_W-1:0] = IDX_W'((base + $urandom_range(0, 5)) % TABLE_SLOTS);
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] pick_live();
        return live_keys[$urandom_range(0, live_keys.size() - 1)];
    endfunction

    task automatic run_mix(input int count, input int ins_pct, input bit clustered);
        int               r;
        int               base;
        logic [1:0]       cmd;
        logic [KEY_W-1:0] k;
        base = 0;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                base = $urandom_range(0, TABLE_SLOTS - 1);
            r = $urandom_range(0, 99);
            if (r < 4)
                cmd = CMD_UNUSED;
            else if (r < 4 + ins_pct)
                cmd = CMD_INSERT;
            else if (r[0])
                cmd = CMD_SEARCH;
            else
                cmd = CMD_REMOVE;
            // hits for search/remove, occasional duplicate inserts
            if (live_keys.size() > 0 &&
                (cmd == CMD_INSERT ? $urandom_range(0, 9) == 0 : $urandom_range(0, 3) != 0))
                k = pick_live();
            else if (clustered)
                k = clustered_key(base);
            else
                k = KEY_W'($urandom);
            apply_op(cmd, k);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // collisions at slot 0, wrap from slot 63, duplicates, shift on remove
        apply_op(CMD_INSERT, 31'd0);
        apply_op(CMD_INSERT, 31'd64);
        apply_op(CMD_INSERT, 31'h7FFF_FFFF);
        apply_op(CMD_INSERT, 31'd127);
        apply_op(CMD_SEARCH, 31'd127);
        apply_op(CMD_SEARCH, 31'h7FFF_FFFF);
        apply_op(CMD_SEARCH, 31'd5);
        apply_op(CMD_INSERT, 31'd0);
        apply_op(CMD_SEARCH, 31'd0);
        apply_op(CMD_REMOVE, 31'd0);
        apply_op(CMD_SEARCH, 31'd0);
        apply_op(CMD_SEARCH, 31'd64);
        apply_op(CMD_REMOVE, 31'h7FFF_FFFF);
        apply_op(CMD_SEARCH, 31'd127);
        apply_op(CMD_REMOVE, 31'd1);
        apply_op(CMD_UNUSED, 31'h7FFF_FFFF);
        apply_op(CMD_UNUSED, 31'd0);
        apply_op(CMD_INSERT, 31'h2AAA_AAAA);
        apply_op(CMD_INSERT, 31'h5555_5555);
        apply_op(CMD_REMOVE, 31'h5555_5555);
        apply_op(CMD_SEARCH, 31'h2AAA_AAAA);

        run_mix(150, 60, 1'b1);

        // output blocked while requests keep coming
        hold_rsp = 1'b1;
        run_mix(40, 45, 1'b1);

        wait_drained();
        no_idle = 1'b1;
        run_mix(100, 45, 1'b1);
        no_idle = 1'b0;
        run_mix(180, 30, 1'b0);

        // full table: failing insert, exhaustive probes, then drain
        while (live_keys.size() < TABLE_SLOTS)
            apply_op(CMD_INSERT, $urandom_range(0, 1) ? clustered_key($urandom_range(0, 63))
                                                      : KEY_W'($urandom));
        apply_op(CMD_INSERT, KEY_W'($urandom));
        apply_op(CMD_INSERT, pick_live());
        apply_op(CMD_SEARCH, KEY_W'($urandom));
        apply_op(CMD_REMOVE, KEY_W'($urandom));
        apply_op(CMD_SEARCH, pick_live());
        while (live_keys.size() > 0)
        begin
            if ($urandom_range(0, 3) == 0)
                apply_op(CMD_SEARCH, pick_live());
            apply_op(CMD_REMOVE, pick_live());
        end
        apply_op(CMD_SEARCH, KEY_W'($urandom));

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("linear_probe_hash_table test passed");
        else
            $display("linear_probe_hash_table test failed");
        $finish;
    end

endmodule
